[design/scu_pkg.sv]
package scu_pkg;

	localparam int ANGLE_W = 32;
	localparam int VALUE_W = 32;
	localparam int DEF_ANGLE_FRAC_BITS = 24;
	localparam int DEF_RESULT_FRAC_BITS = 30;

	localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;

	localparam logic signed [33:0] NUM_COEF [5] = '{
		34'sd3476183291, -34'sd1265384474, 34'sd112666382, -34'sd3544902, 34'sd37368
	};
	localparam logic [31:0] DEN_COEF [5] = '{
		32'd2213007015, 32'd104493882, 32'd2422553, 32'd33959, 32'd256
	};

	typedef struct packed {
		logic [32:0] numm;
		logic [31:0] den;
		logic        neg;
	} div_in_t;

endpackage

[design/scu_in_if.sv]
interface scu_in_if;
	import scu_pkg::*;

	logic               valid;
	logic               ready;
	logic               op;
	logic signed [ANGLE_W-1:0] angle;

	modport source (output valid, output op, output angle, input ready);
	modport sink (input valid, input op, input angle, output ready);
endinterface

[design/scu_out_if.sv]
interface scu_out_if;
	import scu_pkg::*;

	logic               valid;
	logic               ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

[design/scu_div.sv]
module scu_div #(
	parameter int QBITS = scu_pkg::DEF_RESULT_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  scu_pkg::div_in_t     in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [QBITS:0]       q,
	output logic                 big,
	output logic                 neg
);
	import scu_pkg::*;

	logic [QBITS:0]   vld_s;
	logic [QBITS+1:0] en;
	logic [31:0]      rem_s [QBITS+1];
	logic [31:0]      den_s [QBITS+1];
	logic [QBITS:0]   q_s [QBITS+1];
	logic             big_s [QBITS+1];
	logic             neg_s [QBITS+1];

	logic        q0;
	logic [32:0] rem0;

	assign en[QBITS+1] = out_ready;
	assign in_ready = en[0];

	always_comb begin
		q0 = in_data.numm >= {1'b0, in_data.den};
		rem0 = q0 ? in_data.numm - {1'b0, in_data.den} : in_data.numm;
	end

	// first stage: integer bit and overflow check
	assign en[0] = !vld_s[0] || en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			rem_s[0] <= rem0[31:0];
			den_s[0] <= in_data.den;
			q_s[0] <= {{QBITS{1'b0}}, q0};
			big_s[0] <= in_data.numm >= {in_data.den, 1'b0};
			neg_s[0] <= in_data.neg;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		logic [32:0] r2;
		logic        b;
		logic [32:0] rn;

		assign en[k] = !vld_s[k] || en[k+1];

		always_comb begin
			r2 = {rem_s[k-1], 1'b0};
			b = r2 >= {1'b0, den_s[k-1]};
			rn = b ? r2 - {1'b0, den_s[k-1]} : r2;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && vld_s[k-1]) begin
				rem_s[k] <= rn[31:0];
				den_s[k] <= den_s[k-1];
				q_s[k] <= {q_s[k-1][QBITS-1:0], b};
				big_s[k] <= big_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QBITS];
	assign q = q_s[QBITS];
	assign big = big_s[QBITS];
	assign neg = neg_s[QBITS];

endmodule

[design/sine_cosine_unit.sv]
// Throughput: one item per cycle while the output is not stalled; nine arithmetic
// stages, one divider stage per quotient bit, and an output register.
// A stall holds only the stages that are full; empty stages keep filling.
// Reset clears the valid bits of every stage; data registers are not reset.
module sine_cosine_unit #(
	parameter int ANGLE_FRAC_BITS = scu_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int RESULT_FRAC_BITS = scu_pkg::DEF_RESULT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	scu_in_if.sink    din,
	scu_out_if.source dout
);
	import scu_pkg::*;

	localparam int RF = RESULT_FRAC_BITS;

	function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
			input logic [30:0] s);
		logic [33:0] m;
		logic [63:0] p;
		logic [33:0] r;
		m = a[33] ? 34'(-a) : 34'(a);
		p = 64'(m[32:0]) * 64'(s);
		r = p[63:30];
		return a[33] ? $signed(34'(-r)) : $signed(r);
	endfunction

	logic [9:1]  vld_s;
	logic [10:1] en;

	logic [31:0] mag_s1;
	logic [1:0]  quad_s1;
	logic [63:0] prod_s2;
	logic [1:0]  quad_s2;
	logic [30:0] t30_s [3:8];
	logic        neg_s [3:8];
	logic [30:0] sq_s [4:8];
	logic signed [33:0] hn_s [4:8];
	logic [31:0] hd_s [4:8];

	div_in_t div_d;
	logic    div_rdy;
	logic    div_vld;
	logic [RF:0] div_q;
	logic    div_big;
	logic    div_neg;

	logic        vld_o_q;
	logic        en_o;
	logic signed [VALUE_W-1:0] value_q;

	for (genvar k = 1; k <= 9; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end
	assign en[10] = div_rdy;
	assign din.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= din.valid;
			end
			for (int k = 2; k <= 9; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// magnitude and starting quadrant
	always_ff @(posedge clk) begin
		if (en[1] && din.valid) begin
			mag_s1 <= din.angle[ANGLE_W-1] ? 32'(-din.angle) : 32'(din.angle);
			quad_s1 <= {din.angle[ANGLE_W-1] && !din.op, din.op};
		end
	end

	// scale by 2/pi
	always_ff @(posedge clk) begin
		if (en[2] && vld_s[1]) begin
			prod_s2 <= 64'(mag_s1) * 64'(TWO_OVER_PI_Q32);
			quad_s2 <= quad_s1;
		end
	end

	// quadrant and reduced argument
	logic [1:0]  quad3;
	logic [31:0] frac3;
	logic [32:0] t3;
	always_comb begin
		quad3 = quad_s2 + prod_s2[ANGLE_FRAC_BITS+33:ANGLE_FRAC_BITS+32];
		frac3 = prod_s2[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
		t3 = quad3[0] ? 33'h1_0000_0000 - {1'b0, frac3} : {1'b0, frac3};
	end

	always_ff @(posedge clk) begin
		if (en[3] && vld_s[2]) begin
			t30_s[3] <= t3[32:2];
			neg_s[3] <= quad3[1];
		end
	end

	// square
	logic [61:0] sq4;
	assign sq4 = 62'(t30_s[3]) * 62'(t30_s[3]);

	always_ff @(posedge clk) begin
		if (en[4] && vld_s[3]) begin
			sq_s[4] <= sq4[60:30];
			t30_s[4] <= t30_s[3];
			neg_s[4] <= neg_s[3];
			hn_s[4] <= NUM_COEF[4];
			hd_s[4] <= DEN_COEF[4];
		end
	end

	// Horner steps, numerator and denominator side by side
	for (genvar j = 5; j <= 8; j++) begin : g_horner
		logic [62:0] dp;
		assign dp = 63'(hd_s[j-1]) * 63'(sq_s[j-1]);

		always_ff @(posedge clk) begin
			if (en[j] && vld_s[j-1]) begin
				hn_s[j] <= mul_q30(hn_s[j-1], sq_s[j-1]) + NUM_COEF[8-j];
				hd_s[j] <= dp[61:30] + DEN_COEF[8-j];
				sq_s[j] <= sq_s[j-1];
				t30_s[j] <= t30_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	// numerator times t, to sign and magnitude
	logic signed [33:0] num9;
	logic [33:0]        numm9;
	always_comb begin
		num9 = mul_q30(hn_s[8], t30_s[8]);
		numm9 = num9[33] ? 34'(-num9) : 34'(num9);
	end

	always_ff @(posedge clk) begin
		if (en[9] && vld_s[8]) begin
			div_d.numm <= numm9[32:0];
			div_d.den <= hd_s[8];
			div_d.neg <= neg_s[8] ^ num9[33];
		end
	end

	scu_div #(
		.QBITS(RF)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s[9]),
		.in_ready (div_rdy),
		.in_data  (div_d),
		.out_valid(div_vld),
		.out_ready(en_o),
		.q        (div_q),
		.big      (div_big),
		.neg      (div_neg)
	);

	// clamp and sign
	localparam logic [RF:0] ONE = {1'b1, {RF{1'b0}}};
	logic [RF:0] qc;
	always_comb begin
		qc = (div_big || div_q > ONE) ? ONE : div_q;
	end

	assign en_o = !vld_o_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_q <= 1'b0;
		end else if (en_o) begin
			vld_o_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && div_vld) begin
			value_q <= div_neg ? $signed(VALUE_W'(0) - VALUE_W'(qc)) : $signed(VALUE_W'(qc));
		end
	end

	assign dout.valid = vld_o_q;
	assign dout.value = value_q;

	localparam logic signed [VALUE_W-1:0] LIM = VALUE_W'(ONE);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.value <= LIM && dout.value >= -LIM))
		else $error("result outside plus or minus one");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!dout.valid |-> din.ready)
		else $error("input stalled with empty output");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[9] |-> div_d.den != '0)
		else $error("zero denominator");

	a_targ: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] |-> t30_s[3] <= 31'h4000_0000)
		else $error("reduced argument above one");

endmodule
